FILE: rtl/core/tccb_pkg.sv
`timescale 1ns / 1ps

package tccb_pkg;

    // Default geometry of the cell store
    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 64;

    // Configuration registers
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 2'd1;
    localparam logic [7:0] COL_COUNT_RESET = 8'd80;
    localparam logic [6:0] ROW_COUNT_RESET = 7'd25;

    // Field widths of the result cursor
    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 6;

    // Width used for count and limit compares (holds up to 511)
    localparam int CMPW = 9;

    // Request codes
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NUL       = 8'h00;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [5:0] display_line;
        logic [6:0] column;
    } req_t;

    typedef struct packed {
        logic [7:0] cell_byte;
        logic [6:0] cursor_col;
        logic [5:0] cursor_row;
        logic       wrapped;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL_ALL,
        ST_FILL_ROW,
        ST_MOD,
        ST_READ,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic put;
        logic read_latch;
        logic fill_all;
        logic fill_row;
        logic mod_step;
        logic mem_read;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic put_blank;
        logic read_oor;
        logic wrapped;
        logic mod_last;
        logic row_last;
        logic all_last;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/core/text_console_cell_buffer.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// req       in   req_valid/stall    tccb_pkg::req_t (req_type, char_code, display_line, column)
// rsp       out  rsp_valid/stall    tccb_pkg::rsp_t (cell_byte, cursor_col, cursor_row, wrapped)
// cfg       in   cfg_valid/ready    cfg_index, cfg_data (0 col_count, 1 row_count)
//
// One request at a time. A put that enters a row after the wrap also blanks that row.
// A read runs a restoring remainder that maps a line onto the row ring once wrapped.
// Clear sweeps all MAX_ROWS*MAX_COLS cells to spaces; the single memory write port sets
// these sweeps. After reset the store is swept to spaces with req_stall high.
// A finished result sits in the output register; a stalled rsp holds the next request in wait.
module text_console_cell_buffer
#(
    parameter int MAX_COLS = tccb_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tccb_pkg::DEF_MAX_ROWS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  tccb_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output tccb_pkg::rsp_t                    rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tccb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tccb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tccb_pkg::cmd_t    cmd;
    tccb_pkg::status_t status;

    // Sequencer
    tccb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .status    (status),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    // Cell store, cursor and result register
    tccb_datapath
    #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

FILE: rtl/core/tccb_ctrl.sv
`timescale 1ns / 1ps

module tccb_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [1:0]        req_type,
    input  tccb_pkg::status_t status,
    output logic              req_stall,
    output tccb_pkg::cmd_t    cmd
);

    tccb_pkg::state_t state_reg;
    tccb_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tccb_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            tccb_pkg::ST_INIT:
            begin
                // power-up sweep: every cell to space
                cmd.fill_all = 1'b1;
                if (status.all_last)
                begin
                    state_next = tccb_pkg::ST_IDLE;
                end
            end
            tccb_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    unique case (req_type)
                        tccb_pkg::REQ_PUT:
                        begin
                            cmd.put    = 1'b1;
                            state_next = status.put_blank ? tccb_pkg::ST_FILL_ROW
                                                          : tccb_pkg::ST_DONE;
                        end
                        tccb_pkg::REQ_CLEAR:
                        begin
                            state_next = tccb_pkg::ST_FILL_ALL;
                        end
                        tccb_pkg::REQ_READ:
                        begin
                            cmd.read_latch = 1'b1;
                            if (status.read_oor)
                            begin
                                state_next = tccb_pkg::ST_DONE;
                            end
                            else if (status.wrapped)
                            begin
                                state_next = tccb_pkg::ST_MOD;
                            end
                            else
                            begin
                                state_next = tccb_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = tccb_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            tccb_pkg::ST_FILL_ALL:
            begin
                cmd.fill_all = 1'b1;
                if (status.all_last)
                begin
                    state_next = tccb_pkg::ST_DONE;
                end
            end
            tccb_pkg::ST_FILL_ROW:
            begin
                cmd.fill_row = 1'b1;
                if (status.row_last)
                begin
                    state_next = tccb_pkg::ST_DONE;
                end
            end
            tccb_pkg::ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                begin
                    state_next = tccb_pkg::ST_READ;
                end
            end
            tccb_pkg::ST_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = tccb_pkg::ST_DONE;
            end
            tccb_pkg::ST_DONE:
            begin
                // wait for the output register to free up
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = tccb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tccb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/tccb_datapath.sv
`timescale 1ns / 1ps

module tccb_datapath
#(
    parameter int MAX_COLS = tccb_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tccb_pkg::DEF_MAX_ROWS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tccb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tccb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  tccb_pkg::req_t                    req,
    input  tccb_pkg::cmd_t                    cmd,
    output tccb_pkg::status_t                 status,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output tccb_pkg::rsp_t                    rsp
);

    localparam int CMPW  = tccb_pkg::CMPW;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNW   = $clog2(MAX_COLS + 1);
    localparam int RNW   = $clog2(MAX_ROWS + 1);
    localparam int SW    = ((RW > 6) ? RW : 6) + 1;
    localparam int STW   = $clog2(SW);
    localparam int DW    = SW + RNW;
    localparam int MW    = AW + CMPW;
    localparam int COW   = tccb_pkg::COL_OUT_W;
    localparam int ROW   = tccb_pkg::ROW_OUT_W;

    // Cell store
    logic [7:0] mem [DEPTH];

    logic [7:0]     col_count_reg;
    logic [6:0]     row_count_reg;
    logic [CW-1:0]  cur_col_reg;
    logic [RW-1:0]  cur_row_reg;
    logic           wrapped_reg;
    logic [AW-1:0]  walk_reg;
    logic [SW-1:0]  rem_reg;
    logic [STW-1:0] step_reg;
    logic [5:0]     line_reg;
    logic [6:0]     col_reg;
    logic [7:0]     rd_data_reg;
    logic           rd_valid_reg;
    logic           rsp_valid_reg;
    tccb_pkg::rsp_t rsp_reg;

    logic [CNW-1:0] cols_eff;
    logic [RNW-1:0] rows_eff;

    logic           printable;
    logic           is_nl;
    logic           is_bs;
    logic [CW:0]    col_inc;
    logic [RW:0]    row_inc;
    logic [CW-1:0]  col_next;
    logic [RW-1:0]  row_next;
    logic           wrap_next;
    logic           put_blank;
    logic           put_we;
    logic [7:0]     put_data;

    logic [DW-1:0]     div_shift;
    logic [CW+6:0]     col_wide;
    logic [RW+5:0]     line_wide;
    logic [RW-1:0]     rd_row;
    logic [AW-1:0]     rd_addr;
    logic [CW+COW-1:0] cur_col_wide;
    logic [RW+ROW-1:0] cur_row_wide;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic           all_last;
    logic           row_last;

    function automatic logic [AW-1:0] row_base(input logic [RW-1:0] r);
        logic [MW-1:0] p;
        p = MW'(r) * MW'(MAX_COLS);
        return p[AW-1:0];
    endfunction

    // Saturated geometry
    always_comb
    begin
        if (col_count_reg == 8'd0)
        begin
            cols_eff = CNW'(1);
        end
        else if (CMPW'(col_count_reg) > CMPW'(MAX_COLS))
        begin
            cols_eff = CNW'(MAX_COLS);
        end
        else
        begin
            cols_eff = CNW'(col_count_reg);
        end

        if (row_count_reg == 7'd0)
        begin
            rows_eff = RNW'(1);
        end
        else if (CMPW'(row_count_reg) > CMPW'(MAX_ROWS))
        begin
            rows_eff = RNW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = RNW'(row_count_reg);
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= tccb_pkg::COL_COUNT_RESET;
            row_count_reg <= tccb_pkg::ROW_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == tccb_pkg::REG_COL_COUNT)
            begin
                col_count_reg <= cfg_data[7:0];
            end
            else if (cfg_index == tccb_pkg::REG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data[6:0];
            end
        end
    end

    // Character decode and cursor advance
    assign printable = (req.char_code >= tccb_pkg::CH_SPACE) &&
                       (req.char_code <= tccb_pkg::CH_TILDE);
    assign is_nl     = (req.char_code == tccb_pkg::CH_NEWLINE);
    assign is_bs     = (req.char_code == tccb_pkg::CH_BACKSPACE);
    assign put_we    = printable || is_nl;
    assign put_data  = is_nl ? tccb_pkg::CH_NUL : req.char_code;
    assign col_inc   = {1'b0, cur_col_reg} + (CW+1)'(1);
    assign row_inc   = {1'b0, cur_row_reg} + (RW+1)'(1);

    always_comb
    begin
        col_next  = cur_col_reg;
        row_next  = cur_row_reg;
        wrap_next = wrapped_reg;
        put_blank = 1'b0;
        if (is_bs)
        begin
            if (cur_col_reg != '0)
            begin
                col_next = cur_col_reg - CW'(1);
            end
        end
        else if ((CMPW'(col_inc) >= CMPW'(cols_eff)) || is_nl)
        begin
            col_next = '0;
            if (CMPW'(row_inc) >= CMPW'(rows_eff))
            begin
                row_next  = '0;
                wrap_next = 1'b1;
            end
            else
            begin
                row_next = row_inc[RW-1:0];
            end
            put_blank = wrap_next;
        end
        else
        begin
            col_next = col_inc[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (cmd.put)
        begin
            cur_col_reg <= col_next;
            cur_row_reg <= row_next;
            wrapped_reg <= wrap_next;
        end
    end

    // Fill sweep counter, shared by the power-up sweep, clear and row blanking
    assign all_last = (walk_reg == AW'(DEPTH - 1));
    assign row_last = (walk_reg == AW'(CMPW'(cols_eff) - CMPW'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg <= '0;
        end
        else if (cmd.fill_all)
        begin
            walk_reg <= all_last ? '0 : walk_reg + AW'(1);
        end
        else if (cmd.fill_row)
        begin
            walk_reg <= row_last ? '0 : walk_reg + AW'(1);
        end
    end

    // Write port select
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = walk_reg;
        mem_wdata = tccb_pkg::CH_SPACE;
        if (cmd.fill_all)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.fill_row)
        begin
            mem_we    = 1'b1;
            mem_waddr = row_base(cur_row_reg) + walk_reg;
        end
        else if (cmd.put)
        begin
            mem_we    = put_we;
            mem_waddr = row_base(cur_row_reg) + AW'(cur_col_reg);
            mem_wdata = put_data;
        end
    end

    // Read request latch and ring-row remainder (restoring, one bit per cycle)
    assign div_shift = DW'(rows_eff) << step_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.read_latch)
        begin
            line_reg <= req.display_line;
            col_reg  <= req.column;
            rem_reg  <= SW'(req.display_line) + SW'(cur_row_reg) + SW'(1);
            step_reg <= STW'(SW - 1);
        end
        else if (cmd.mod_step)
        begin
            if (DW'(rem_reg) >= div_shift)
            begin
                rem_reg <= rem_reg - div_shift[SW-1:0];
            end
            step_reg <= step_reg - STW'(1);
        end
    end

    // Read address
    assign col_wide  = (CW+7)'(col_reg);
    assign line_wide = (RW+6)'(line_reg);
    assign rd_row    = wrapped_reg ? rem_reg[RW-1:0] : line_wide[RW-1:0];
    assign rd_addr   = row_base(rd_row) + AW'(col_wide[CW-1:0]);

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_read)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (cmd.mem_read)
        begin
            rd_valid_reg <= 1'b1;
        end
        else if (cmd.out_load)
        begin
            rd_valid_reg <= 1'b0;
        end
    end

    // Result register
    assign cur_col_wide = (CW+COW)'(cur_col_reg);
    assign cur_row_wide = (RW+ROW)'(cur_row_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg.cell_byte  <= rd_valid_reg ? rd_data_reg : tccb_pkg::CH_NUL;
            rsp_reg.cursor_col <= cur_col_wide[COW-1:0];
            rsp_reg.cursor_row <= cur_row_wide[ROW-1:0];
            rsp_reg.wrapped    <= wrapped_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Status to controller
    assign status.put_blank = put_blank;
    assign status.read_oor  = (CMPW'(req.display_line) >= CMPW'(rows_eff)) ||
                              (CMPW'(req.column) >= CMPW'(cols_eff));
    assign status.wrapped   = wrapped_reg;
    assign status.mod_last  = (step_reg == '0);
    assign status.row_last  = row_last;
    assign status.all_last  = all_last;
    assign status.out_free  = !rsp_valid_reg || !rsp_stall;

    // Checks
    a_no_rsp_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(rsp_valid_reg && rsp_stall))
        else $error("result register loaded while a result is held");

    a_ring_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_read && wrapped_reg) |-> (CMPW'(rem_reg) < CMPW'(rows_eff)))
        else $error("ring row remainder not reduced below row count");

    a_blank_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_row |-> (CMPW'(walk_reg) < CMPW'(cols_eff)))
        else $error("row blanking walked past the row width");

    a_wrap_to_top: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(wrapped_reg) |-> (cur_row_reg == '0))
        else $error("wrap flag set without cursor returning to the top row");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int NCOLS      = tccb_pkg::DEF_MAX_COLS;
    localparam int NROWS      = tccb_pkg::DEF_MAX_ROWS;
    localparam int IDLE_LIMIT = 40000;
    localparam int LONG_HOLD  = 120;
    localparam int MAX_REPORT = 60;

    // request code with no function; the block must leave everything alone
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                             req_valid = 1'b0;
    logic                             req_stall;
    tccb_pkg::req_t                   req       = '0;
    logic                             rsp_valid;
    logic                             rsp_stall = 1'b0;
    tccb_pkg::rsp_t                   rsp;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [tccb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [tccb_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    always #5 clk = ~clk;

    text_console_cell_buffer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the console: cell store, cursor, wrap flag, geometry
    logic [7:0] shadow_cells [0:NCOLS*NROWS-1];
    int         shadow_col;
    int         shadow_row;
    logic       shadow_wrapped;
    logic [7:0] shadow_col_count;
    logic [6:0] shadow_row_count;

    tccb_pkg::req_t pending_requests [$];
    tccb_pkg::rsp_t expected_cursor [$];

    bit quiet_run = 1'b0;
    int n_err     = 0;
    int n_checked = 0;

    function automatic int active_cols();
        if (shadow_col_count == 0) return 1;
        if (shadow_col_count > NCOLS) return NCOLS;
        return int'(shadow_col_count);
    endfunction

    function automatic int active_rows();
        if (shadow_row_count == 0) return 1;
        if (shadow_row_count > NROWS) return NROWS;
        return int'(shadow_row_count);
    endfunction

    // Apply one request to the shadow console and return the result it gives
    function automatic tccb_pkg::rsp_t console_step(tccb_pkg::req_t r);
        tccb_pkg::rsp_t o;
        int   cols;
        int   rows;
        int   at;
        int   row;
        int   c;
        o    = '0;
        cols = active_cols();
        rows = active_rows();
        unique case (r.req_type)
            tccb_pkg::REQ_PUT:
            begin
                at = shadow_row * NCOLS + shadow_col;
                if (r.char_code >= tccb_pkg::CH_SPACE && r.char_code <= tccb_pkg::CH_TILDE)
                    shadow_cells[at] = r.char_code;
                else if (r.char_code == tccb_pkg::CH_NEWLINE)
                    shadow_cells[at] = tccb_pkg::CH_NUL;
                if (r.char_code == tccb_pkg::CH_BACKSPACE)
                begin
                    if (shadow_col > 0)
                        shadow_col--;
                end
                else
                begin
                    shadow_col++;
                    if (shadow_col >= cols || r.char_code == tccb_pkg::CH_NEWLINE)
                    begin
                        shadow_col = 0;
                        shadow_row++;
                        if (shadow_row >= rows)
                        begin
                            shadow_row     = 0;
                            shadow_wrapped = 1'b1;
                        end
                        // once wrapped, each row entered starts blank
                        if (shadow_wrapped)
                            for (c = 0; c < cols; c++)
                                shadow_cells[shadow_row * NCOLS + c] = tccb_pkg::CH_SPACE;
                    end
                end
            end
            tccb_pkg::REQ_CLEAR:
            begin
                for (c = 0; c < NCOLS * NROWS; c++)
                    shadow_cells[c] = tccb_pkg::CH_SPACE;
            end
            tccb_pkg::REQ_READ:
            begin
                if (r.display_line < rows && r.column < cols)
                begin
                    row = int'(r.display_line);
                    if (shadow_wrapped)
                        row = (int'(r.display_line) + shadow_row + 1) % rows;
                    o.cell_byte = shadow_cells[row * NCOLS + int'(r.column)];
                end
            end
            default:
            begin
            end
        endcase
        o.cursor_col = shadow_col[tccb_pkg::COL_OUT_W-1:0];
        o.cursor_row = shadow_row[tccb_pkg::ROW_OUT_W-1:0];
        o.wrapped    = shadow_wrapped;
        return o;
    endfunction

    // Random request; reads mostly land inside the visible window
    function automatic tccb_pkg::req_t random_request(int nl_pct);
        tccb_pkg::req_t r;
        int   pick;
        int   sub;
        r.req_type     = tccb_pkg::REQ_PUT;
        r.char_code    = 8'($urandom);
        r.display_line = 6'($urandom);
        r.column       = 7'($urandom);
        pick = int'($urandom_range(0, 99));
        if (pick < 22)
        begin
            r.req_type = tccb_pkg::REQ_READ;
            if ($urandom_range(0, 9) != 0)
            begin
                r.display_line = 6'($urandom_range(0, active_rows() - 1));
                r.column       = 7'($urandom_range(0, active_cols() - 1));
            end
        end
        else if (pick < 24)
            r.req_type = REQ_UNUSED;
        else
        begin
            sub = int'($urandom_range(0, 99));
            if (sub < nl_pct)
                r.char_code = tccb_pkg::CH_NEWLINE;
            else if (sub < nl_pct + 8)
                r.char_code = tccb_pkg::CH_BACKSPACE;
            else if (sub >= nl_pct + 14)
                r.char_code = 8'($urandom_range(tccb_pkg::CH_SPACE, tccb_pkg::CH_TILDE));
        end
        return r;
    endfunction

    task automatic queue_request(input logic [1:0] kind, input logic [7:0] ch,
                                 input int line, input int col);
        tccb_pkg::req_t r;
        r.req_type     = kind;
        r.char_code    = ch;
        r.display_line = 6'(line);
        r.column       = 7'(col);
        pending_requests.push_back(r);
    endtask

    task automatic queue_random(input int count, input int nl_pct);
        repeat (count) pending_requests.push_back(random_request(nl_pct));
    endtask

    // Register write; the shadow geometry follows at the handshake
    task automatic write_register(input logic [tccb_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [tccb_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == tccb_pkg::REG_COL_COUNT)
            shadow_col_count = val;
        else if (idx == tccb_pkg::REG_ROW_COUNT)
            shadow_row_count = val[6:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input logic [7:0] cols, input logic [7:0] rows);
        write_register(tccb_pkg::REG_COL_COUNT, cols);
        write_register(tccb_pkg::REG_ROW_COUNT, rows);
    endtask

    // Sender stays quiet until every queued request has its result back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || req_valid || expected_cursor.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Request driver with random gaps
    int send_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            send_gap  <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_cursor.push_back(console_step(req));
            if (!req_valid || !req_stall)
            begin
                if (send_gap != 0)
                begin
                    req_valid <= 1'b0;
                    send_gap  <= send_gap - 1;
                end
                else if (!quiet_run && $urandom_range(0, 9) == 0)
                begin
                    req_valid <= 1'b0;
                    send_gap  <= int'($urandom_range(0, 4));
                end
                else if (pending_requests.size() != 0)
                begin
                    req       <= pending_requests.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Result checker with random stalls and two long hold-offs
    int             hold_cnt   = 0;
    bit             held_first = 1'b0;
    bit             held_again = 1'b0;
    tccb_pkg::rsp_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_cnt  <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                n_checked++;
                if (expected_cursor.size() == 0)
                begin
                    n_err++;
                    if (n_err < MAX_REPORT)
                        $display("%0t: result with no request pending: %p", $time, rsp);
                end
                else
                begin
                    want = expected_cursor.pop_front();
                    if (rsp.cell_byte !== want.cell_byte)
                    begin
                        n_err++;
                        if (n_err < MAX_REPORT)
                            $display("%0t: cell_byte expected %h actual %h",
                                     $time, want.cell_byte, rsp.cell_byte);
                    end
                    if (rsp.cursor_col !== want.cursor_col)
                    begin
                        n_err++;
                        if (n_err < MAX_REPORT)
                            $display("%0t: cursor_col expected %0d actual %0d",
                                     $time, want.cursor_col, rsp.cursor_col);
                    end
                    if (rsp.cursor_row !== want.cursor_row)
                    begin
                        n_err++;
                        if (n_err < MAX_REPORT)
                            $display("%0t: cursor_row expected %0d actual %0d",
                                     $time, want.cursor_row, rsp.cursor_row);
                    end
                    if (rsp.wrapped !== want.wrapped)
                    begin
                        n_err++;
                        if (n_err < MAX_REPORT)
                            $display("%0t: wrapped expected %b actual %b",
                                     $time, want.wrapped, rsp.wrapped);
                    end
                end
            end
            if (hold_cnt != 0)
            begin
                rsp_stall <= 1'b1;
                hold_cnt  <= hold_cnt - 1;
            end
            else if ((n_checked >= 200 && !held_first) || (n_checked >= 1000 && !held_again))
            begin
                // back-pressure long enough for the block to stall its input
                if (n_checked >= 1000)
                    held_again <= 1'b1;
                held_first <= 1'b1;
                rsp_stall  <= 1'b1;
                hold_cnt   <= LONG_HOLD;
            end
            else if (!quiet_run && $urandom_range(0, 7) == 0)
            begin
                rsp_stall <= 1'b1;
                hold_cnt  <= int'($urandom_range(0, 4));
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no handshake on any channel
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int k;
        for (k = 0; k < NCOLS * NROWS; k++)
            shadow_cells[k] = tccb_pkg::CH_SPACE;
        shadow_col       = 0;
        shadow_row       = 0;
        shadow_wrapped   = 1'b0;
        shadow_col_count = tccb_pkg::COL_COUNT_RESET;
        shadow_row_count = tccb_pkg::ROW_COUNT_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass at reset geometry
        queue_request(tccb_pkg::REQ_PUT, tccb_pkg::CH_SPACE, 0, 0);
        queue_request(tccb_pkg::REQ_PUT, tccb_pkg::CH_TILDE, 63, 127);
        queue_request(tccb_pkg::REQ_PUT, 8'h1F, 0, 0);
        queue_request(tccb_pkg::REQ_PUT, 8'h7F, 0, 0);
        queue_request(tccb_pkg::REQ_PUT, 8'hFF, 0, 0);
        queue_request(tccb_pkg::REQ_PUT, tccb_pkg::CH_NUL, 0, 0);
        queue_request(tccb_pkg::REQ_READ, 8'hFF, 0, 0);
        queue_request(tccb_pkg::REQ_READ, tccb_pkg::CH_NUL, 0, 1);
        queue_request(tccb_pkg::REQ_READ, tccb_pkg::CH_NUL, 0, 2);
        queue_request(tccb_pkg::REQ_PUT, tccb_pkg::CH_BACKSPACE, 0, 0);
        queue_request(tccb_pkg::REQ_PUT, 8'h41, 0, 0);
        queue_request(tccb_pkg::REQ_READ, tccb_pkg::CH_NUL, 0, 4);
        queue_request(tccb_pkg::REQ_PUT, tccb_pkg::CH_NEWLINE, 0, 0);
        queue_request(tccb_pkg::REQ_READ, tccb_pkg::CH_NUL, 0, 5);
        // backspace at column zero keeps the cursor put
        queue_request(tccb_pkg::REQ_PUT, tccb_pkg::CH_BACKSPACE, 0, 0);
        queue_request(tccb_pkg::REQ_READ, tccb_pkg::CH_NUL, 24, 79);
        // reads outside the window return zero
        queue_request(tccb_pkg::REQ_READ, tccb_pkg::CH_NUL, 63, 0);
        queue_request(tccb_pkg::REQ_READ, tccb_pkg::CH_NUL, 0, 127);
        queue_request(tccb_pkg::REQ_READ, tccb_pkg::CH_NUL, 25, 80);
        queue_request(REQ_UNUSED, 8'hFF, 63, 127);
        queue_request(tccb_pkg::REQ_CLEAR, 8'hA5, 21, 85);
        queue_request(tccb_pkg::REQ_READ, tccb_pkg::CH_NUL, 0, 1);
        queue_request(tccb_pkg::REQ_PUT, 8'h5A, 0, 0);
        queue_request(tccb_pkg::REQ_READ, tccb_pkg::CH_NUL, 1, 0);
        wait_drained();

        // Reset geometry written back, then random traffic (first long hold here)
        set_geometry(8'd80, 8'd25);
        queue_random(250, 10);
        wait_drained();

        // Smallest geometry: every put other than a backspace wraps the single row
        set_geometry(8'd1, 8'd1);
        queue_random(150, 10);
        wait_drained();

        // Largest geometry, newline heavy so the ring wraps
        set_geometry(8'd128, 8'd64);
        queue_random(300, 45);
        wait_drained();

        // Zero values saturate up to one
        set_geometry(8'd0, 8'd0);
        queue_random(100, 10);
        wait_drained();

        // Oversized values saturate down; row register keeps its low seven bits
        set_geometry(8'd255, 8'hC8);
        queue_random(70, 30);
        queue_request(tccb_pkg::REQ_CLEAR, 8'h00, 0, 0);
        queue_random(80, 30);
        wait_drained();

        // Shrink under the cursor: puts land past the window, then wrap
        set_geometry(8'd5, 8'd3);
        queue_random(150, 10);
        wait_drained();

        set_geometry(8'd129, 8'd127);
        queue_random(150, 40);
        wait_drained();

        // Random geometries
        repeat (3)
        begin
            set_geometry(8'($urandom_range(1, 128)), 8'($urandom_range(1, 64)));
            queue_random(70, int'($urandom_range(0, 20)));
            queue_request(tccb_pkg::REQ_CLEAR, 8'($urandom), int'($urandom_range(0, 63)),
                          int'($urandom_range(0, 127)));
            queue_random(80, int'($urandom_range(0, 20)));
            wait_drained();
        end

        // Closing stretch at full rate on both sides
        quiet_run = 1'b1;
        set_geometry(8'd40, 8'd10);
        queue_random(200, 3);
        wait_drained();

        repeat (20) @(posedge clk);
        if (n_err == 0 && expected_cursor.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/tccb_pkg.sv
rtl/core/tccb_ctrl.sv
rtl/core/tccb_datapath.sv
rtl/core/text_console_cell_buffer.sv
bench/tb_top.sv
